[hdl/spaq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue package
// Shared widths, command codes and the control word sent to the storage cells.
// ----------------------------------------------------------------------------
package spaq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int VALUE_W       = 32;
  localparam int CMD_W         = 3;
  localparam int SLOT_W        = 4;
  localparam int ENTRY_COUNT_W = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH         = 3'd0,
    CMD_POP_MAX      = 3'd1,
    CMD_FIND         = 3'd2,
    CMD_REMOVE_VALUE = 3'd3,
    CMD_REMOVE_AT    = 3'd4
  } command_e;

  typedef enum logic [1:0] {
    CELL_HOLD         = 2'd0,
    CELL_INSERT       = 2'd1,
    CELL_DELETE_MATCH = 2'd2,
    CELL_DELETE_SLOT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    value_t             value;
    logic [SLOT_W-1:0]  slot;
  } cell_ctl_t;

endpackage

[hdl/sorted_array_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue unit
// Bounded store of signed values kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Push, remove-largest, find and remove-at each complete in the cycle that
// accepts them, since every cell compares its entry with the operand at
// once and an insertion or deletion moves the entries from its point
// upward by one slot. Remove-value deletes the stored copies of the value
// one by one, as the cell row closes one gap per cycle. Each result sits in
// an output register; a new command is taken once that register is free or
// being read, and not while a remove-value is still deleting copies.
module sorted_array_priority_queue_unit #(
  parameter int DEPTH = spaq_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [spaq_pkg::CMD_W-1:0]          command_i,
  input  logic signed [spaq_pkg::VALUE_W-1:0] value_i,
  input  logic [spaq_pkg::SLOT_W-1:0]         slot_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic [spaq_pkg::SLOT_W-1:0]         found_slot_o,
  output logic [spaq_pkg::ENTRY_COUNT_W-1:0]  entry_count_o
);
  import spaq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PURGE = 2'b10
  } state_e;

  state_e                    state_q;
  state_e                    state_d;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          count_d;
  value_t                    value_q;
  logic                      out_valid_q;
  logic                      ok_q;
  logic                      ok_d;
  logic [SLOT_W-1:0]         found_q;
  logic [SLOT_W-1:0]         found_d;
  logic [ENTRY_COUNT_W-1:0]  entry_count_q;
  logic                      load_out;
  logic                      accept;
  logic                      out_free;
  logic                      any_match;
  logic                      full;
  logic                      empty;
  logic                      slot_ok;
  logic [SLOT_W-1:0]         first_slot;
  cell_ctl_t                 ctl;

  value_t                    entry_w   [DEPTH];
  value_t                    left_entry [DEPTH];
  value_t                    right_entry[DEPTH];
  logic [DEPTH-1:0]          valid_w;
  logic [DEPTH-1:0]          above_w;
  logic [DEPTH-1:0]          left_above;
  logic [DEPTH-1:0]          match_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid_w[i] = CNT_W'(i) < count_q;
    if (i == 0) begin : g_first
      assign left_entry[i] = '0;
      assign left_above[i] = 1'b0;
    end else begin : g_inner
      assign left_entry[i] = entry_w[i-1];
      assign left_above[i] = above_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry[i] = '0;
    end else begin : g_next
      assign right_entry[i] = entry_w[i+1];
    end

    spaq_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i              (clk_i),
      .ctl_i              (ctl),
      .valid_i            (valid_w[i]),
      .left_entry_i       (left_entry[i]),
      .left_at_or_above_i (left_above[i]),
      .right_entry_i      (right_entry[i]),
      .entry_o            (entry_w[i]),
      .at_or_above_o      (above_w[i]),
      .match_o            (match_w[i])
    );
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign any_match  = |match_w;
  assign full       = count_q == CNT_W'(DEPTH);
  assign empty      = count_q == '0;
  assign slot_ok    = CMP_W'(slot_i) < CMP_W'(count_q);

  always_comb begin
    logic prev;
    prev       = 1'b0;
    first_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_w[i] && !prev) begin
        first_slot = first_slot | SLOT_W'(i);
      end
      prev = match_w[i];
    end
  end

  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = (state_q == ST_PURGE) ? value_q : value_i;
    ctl.slot  = slot_i;
    state_d   = state_q;
    count_d   = count_q;
    load_out  = 1'b0;
    ok_d      = 1'b0;
    found_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (command_i)
            CMD_PUSH: begin
              if (!full) begin
                ctl.op  = CELL_INSERT;
                count_d = count_q + CNT_W'(1);
                ok_d    = 1'b1;
              end
            end
            CMD_POP_MAX: begin
              if (!empty) begin
                count_d = count_q - CNT_W'(1);
                ok_d    = 1'b1;
              end
            end
            CMD_FIND: begin
              ok_d    = any_match;
              found_d = first_slot;
            end
            CMD_REMOVE_VALUE: begin
              if (any_match) begin
                ctl.op   = CELL_DELETE_MATCH;
                count_d  = count_q - CNT_W'(1);
                load_out = 1'b0;
                state_d  = ST_PURGE;
              end
            end
            CMD_REMOVE_AT: begin
              if (slot_ok) begin
                ctl.op  = CELL_DELETE_SLOT;
                count_d = count_q - CNT_W'(1);
                ok_d    = 1'b1;
              end
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_PURGE: begin
        if (any_match) begin
          ctl.op  = CELL_DELETE_MATCH;
          count_d = count_q - CNT_W'(1);
        end else if (out_free) begin
          load_out = 1'b1;
          ok_d     = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
    end
    if (load_out) begin
      ok_q          <= ok_d;
      found_q       <= found_d;
      entry_count_q <= ENTRY_COUNT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign found_slot_o  = found_q;
  assign entry_count_o = entry_count_q;

endmodule

[hdl/spaq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array priority queue storage cell
// Holds one entry, compares it with the operand and takes a neighbor's entry
// when an insertion or deletion shifts the row.
// ----------------------------------------------------------------------------
module spaq_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk_i,
  input  spaq_pkg::cell_ctl_t ctl_i,
  input  logic               valid_i,
  input  spaq_pkg::value_t   left_entry_i,
  input  logic               left_at_or_above_i,
  input  spaq_pkg::value_t   right_entry_i,
  output spaq_pkg::value_t   entry_o,
  output logic               at_or_above_o,
  output logic               match_o
);
  import spaq_pkg::*;

  value_t entry_q;
  value_t entry_d;

  assign at_or_above_o = !valid_i || ($signed(entry_q) >= $signed(ctl_i.value));
  assign match_o       = valid_i && (entry_q == ctl_i.value);
  assign entry_o       = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      CELL_INSERT: begin
        if (left_at_or_above_i) begin
          entry_d = left_entry_i;
        end else if (at_or_above_o) begin
          entry_d = ctl_i.value;
        end
      end
      CELL_DELETE_MATCH: begin
        if (at_or_above_o) begin
          entry_d = right_entry_i;
        end
      end
      CELL_DELETE_SLOT: begin
        if (INDEX >= int'(ctl_i.slot)) begin
          entry_d = right_entry_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
